FILE: design/per_user_flood_detector_defines.svh
// assertion helpers used by the checker file
`ifndef PER_USER_FLOOD_DETECTOR_DEFINES_SVH
`define PER_USER_FLOOD_DETECTOR_DEFINES_SVH

// antecedent and consequent in the same cycle
`define PUFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define PUFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pufd_pkg.sv
package pufd_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int KEY_W    = 32;
    localparam int TIME_W   = 48;
    localparam int COUNT_W  = 8;
    localparam int GAP_W    = 20;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    // register index codes (byte address bits 3:2)
    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_GAP_LIMIT = 2'd1;
    localparam logic [1:0] REG_BURST     = 2'd2;
    localparam logic [1:0] REG_WARN      = 2'd3;

    // reset values of the registers
    localparam logic               ENABLE_RST    = 1'b1;
    localparam logic [GAP_W-1:0]   GAP_LIMIT_RST = 20'd1000;
    localparam logic [COUNT_W-1:0] BURST_RST     = 8'd5;
    localparam logic [COUNT_W-1:0] WARN_RST      = 8'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  sender_key;
        logic [TIME_W-1:0] time_ms;
    } msg_t;

    typedef struct packed {
        logic kick;
        logic ban;
        logic tracked;
    } res_t;

    typedef struct packed {
        logic               enable;
        logic [GAP_W-1:0]   gap_limit_ms;
        logic [COUNT_W-1:0] burst_number;
        logic [COUNT_W-1:0] warning_limit;
    } cfg_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [TIME_W-1:0]  last_time;
        logic [COUNT_W-1:0] burst_count;
        logic [COUNT_W-1:0] warnings;
    } entry_t;

endpackage

FILE: design/per_user_flood_detector.sv
// per-sender flood detector: each message word (sender_key, time_ms) is looked up in a
// table of up to TABLE_ENTRIES senders held in one single-port-write, registered-read RAM.
// the sequencer walks the table one entry per cycle from slot 0 up to the fill count,
// comparing keys with one shared comparator; a hit goes through a gap check cycle and an
// update cycle that writes the entry back, a miss inserts the sender at the fill count
// (or leaves it untracked once the table is full). with tracking on, the time a message
// takes is set by the linear key scan through the RAM read port. msg_stall stays high
// while a message is in work; the result word sits in an output register so a new message
// can be taken while the previous result is still stalled. the table needs no clearing
// pass after reset: entries below the fill count are the valid ones, and fill is cleared
// by reset.
// registers (APB, byte address 4*i): enable, gap_limit_ms, burst_number, warning_limit;
// write them only while the block is idle.
module per_user_flood_detector #(
    parameter int TABLE_ENTRIES = pufd_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // message channel
    input  logic                          msg_valid,
    output logic                          msg_stall,
    input  pufd_pkg::msg_t                msg,
    // result channel
    output logic                          res_valid,
    input  logic                          res_stall,
    output pufd_pkg::res_t                res,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pufd_pkg::PADDR_W-1:0]  paddr,
    input  logic [pufd_pkg::PDATA_W-1:0]  pwdata,
    output logic [pufd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W = $bits(pufd_pkg::entry_t);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_ENTRIES);

    // sequencer state codes
    localparam int         ST_W    = 3;
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_GAP  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;

    pufd_pkg::cfg_t cfg;

    logic [ST_W-1:0]  state_reg,    state_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             cmp_vld_reg,  cmp_vld_next;
    logic [CNT_W-1:0] fill_reg,     fill_next;
    logic             res_valid_reg, res_valid_next;

    logic [pufd_pkg::KEY_W-1:0]  key_reg,   key_next;
    logic [pufd_pkg::TIME_W-1:0] time_reg,  time_next;
    logic [IDX_W-1:0]            cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]            slot_reg,  slot_next;
    pufd_pkg::entry_t            entry_reg, entry_next;
    logic                        gap_hit_reg, gap_hit_next;
    pufd_pkg::res_t              result_reg, result_next;
    pufd_pkg::res_t              res_reg,   res_next;

    // ram port signals
    logic               ram_we;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;
    pufd_pkg::entry_t   rd_entry;
    pufd_pkg::entry_t   new_entry;
    pufd_pkg::entry_t   upd_entry;

    // update arithmetic
    logic [pufd_pkg::TIME_W-1:0]  time_diff;
    logic [pufd_pkg::COUNT_W-1:0] cnt_inc;
    logic [pufd_pkg::COUNT_W-1:0] warn_inc;
    logic                         upd_kick;
    logic                         upd_ban;
    logic                         key_hit;

    pufd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pufd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_entry = pufd_pkg::entry_t'(ram_rd_data);

    // read data belongs to the slot issued in the cycle before
    assign key_hit = cmp_vld_reg && (rd_entry.key == key_reg);

    // fresh entry for a new sender
    assign new_entry.key         = key_reg;
    assign new_entry.last_time   = time_reg;
    assign new_entry.burst_count = pufd_pkg::COUNT_W'(1);
    assign new_entry.warnings    = '0;

    // wide subtract and compare, done in the gap cycle
    assign time_diff = time_reg - entry_reg.last_time;

    // count and warning update, done in the update cycle
    always_comb
    begin
        if (!gap_hit_reg)
        begin
            cnt_inc = pufd_pkg::COUNT_W'(1);
        end
        else if (entry_reg.burst_count == pufd_pkg::COUNT_MAX)
        begin
            cnt_inc = pufd_pkg::COUNT_MAX;
        end
        else
        begin
            cnt_inc = entry_reg.burst_count + pufd_pkg::COUNT_W'(1);
        end

        if (entry_reg.warnings == pufd_pkg::COUNT_MAX)
        begin
            warn_inc = pufd_pkg::COUNT_MAX;
        end
        else
        begin
            warn_inc = entry_reg.warnings + pufd_pkg::COUNT_W'(1);
        end

        upd_kick = (cnt_inc >= cfg.burst_number);
        upd_ban  = upd_kick && (warn_inc > cfg.warning_limit);

        upd_entry.key         = entry_reg.key;
        upd_entry.last_time   = time_reg;
        upd_entry.burst_count = upd_kick ? pufd_pkg::COUNT_W'(1) : cnt_inc;
        upd_entry.warnings    = upd_kick ? warn_inc : entry_reg.warnings;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        fill_next      = fill_reg;
        res_valid_next = res_valid_reg;
        key_next       = key_reg;
        time_next      = time_reg;
        cmp_idx_next   = cmp_idx_reg;
        slot_next      = slot_reg;
        entry_next     = entry_reg;
        gap_hit_next   = gap_hit_reg;
        result_next    = result_reg;
        res_next       = res_reg;

        ram_we      = 1'b0;
        ram_wr_addr = slot_reg;
        ram_wr_data = upd_entry;
        ram_rd_en   = 1'b0;
        ram_rd_addr = scan_idx_reg[IDX_W-1:0];

        // result taken downstream
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    key_next      = msg.sender_key;
                    time_next     = msg.time_ms;
                    scan_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                    result_next   = '0;
                    // disabled: nothing tracked, straight to the result
                    state_next    = cfg.enable ? ST_SCAN : ST_RESP;
                end
            end

            ST_SCAN:
            begin
                if (key_hit)
                begin
                    slot_next    = cmp_idx_reg;
                    entry_next   = rd_entry;
                    cmp_vld_next = 1'b0;
                    state_next   = ST_GAP;
                end
                else if (scan_idx_reg < fill_reg)
                begin
                    // issue the next read, compare next cycle
                    ram_rd_en     = 1'b1;
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_idx_reg[IDX_W-1:0];
                end
                else
                begin
                    // no match: insert if there is room
                    cmp_vld_next = 1'b0;
                    if (fill_reg < DEPTH_C)
                    begin
                        ram_we              = 1'b1;
                        ram_wr_addr         = fill_reg[IDX_W-1:0];
                        ram_wr_data         = new_entry;
                        fill_next           = fill_reg + CNT_W'(1);
                        result_next.tracked = 1'b1;
                    end
                    state_next = ST_RESP;
                end
            end

            ST_GAP:
            begin
                // time going backwards counts as a zero gap, short unless the limit is zero
                gap_hit_next = (time_reg < entry_reg.last_time) ?
                               (cfg.gap_limit_ms != '0) :
                               (time_diff < {{(pufd_pkg::TIME_W-pufd_pkg::GAP_W){1'b0}},
                                             cfg.gap_limit_ms});
                state_next   = ST_UPD;
            end

            ST_UPD:
            begin
                ram_we              = 1'b1;
                result_next.kick    = upd_kick;
                result_next.ban     = upd_ban;
                result_next.tracked = 1'b1;
                state_next          = ST_RESP;
            end

            ST_RESP:
            begin
                // wait for the output register to free up
                if (!res_valid_reg || !res_stall)
                begin
                    res_next       = result_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        time_reg    <= time_next;
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        entry_reg   <= entry_next;
        gap_hit_reg <= gap_hit_next;
        result_reg  <= result_next;
        res_reg     <= res_next;
    end

    assign msg_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: design/pufd_ram.sv
module pufd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/pufd_cfg.sv
module pufd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pufd_pkg::PADDR_W-1:0]  paddr,
    input  logic [pufd_pkg::PDATA_W-1:0]  pwdata,
    output logic [pufd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output pufd_pkg::cfg_t                cfg
);

    logic                                enable_reg;
    logic [pufd_pkg::GAP_W-1:0]          gap_limit_reg;
    logic [pufd_pkg::COUNT_W-1:0]        burst_reg;
    logic [pufd_pkg::COUNT_W-1:0]        warn_reg;
    logic                                wr_en;
    logic [1:0]                          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= pufd_pkg::ENABLE_RST;
            gap_limit_reg <= pufd_pkg::GAP_LIMIT_RST;
            burst_reg     <= pufd_pkg::BURST_RST;
            warn_reg      <= pufd_pkg::WARN_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                pufd_pkg::REG_ENABLE:    enable_reg    <= pwdata[0];
                pufd_pkg::REG_GAP_LIMIT: gap_limit_reg <= pwdata[pufd_pkg::GAP_W-1:0];
                pufd_pkg::REG_BURST:     burst_reg     <= pwdata[pufd_pkg::COUNT_W-1:0];
                pufd_pkg::REG_WARN:      warn_reg      <= pwdata[pufd_pkg::COUNT_W-1:0];
                default:                 enable_reg    <= enable_reg;
            endcase
        end
    end

    // read back, zero extended
    always_comb
    begin
        unique case (reg_sel)
            pufd_pkg::REG_ENABLE:
                prdata = {{(pufd_pkg::PDATA_W-1){1'b0}}, enable_reg};
            pufd_pkg::REG_GAP_LIMIT:
                prdata = {{(pufd_pkg::PDATA_W-pufd_pkg::GAP_W){1'b0}}, gap_limit_reg};
            pufd_pkg::REG_BURST:
                prdata = {{(pufd_pkg::PDATA_W-pufd_pkg::COUNT_W){1'b0}}, burst_reg};
            pufd_pkg::REG_WARN:
                prdata = {{(pufd_pkg::PDATA_W-pufd_pkg::COUNT_W){1'b0}}, warn_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.enable        = enable_reg;
    assign cfg.gap_limit_ms  = gap_limit_reg;
    assign cfg.burst_number  = burst_reg;
    assign cfg.warning_limit = warn_reg;

endmodule

FILE: design/pufd_chk.sv
`include "per_user_flood_detector_defines.svh"

module pufd_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           msg_valid,
    input logic           msg_stall,
    input logic           res_valid,
    input logic           res_stall,
    input pufd_pkg::res_t res
);

    // block goes busy right after taking a message
    `PUFD_ASSERT_NEXT(busy_after_accept, msg_valid && !msg_stall, msg_stall, "no stall after accept")

    // a new result word only shows as the block returns to idle
    `PUFD_ASSERT_SAME(idle_on_result, $rose(res_valid), !msg_stall, "result while still busy")

    // a ban always comes with a kick for a tracked sender
    `PUFD_ASSERT_SAME(ban_needs_kick, res_valid && res.ban, res.kick && res.tracked, "ban without kick")

    // stalled result word holds
    `PUFD_ASSERT_NEXT(res_hold, res_valid && res_stall, res_valid && $stable(res), "result dropped")

endmodule

bind per_user_flood_detector pufd_chk u_pufd_chk (.*);
